[sv/ipv4_dotted_text_parser_assert.svh]
// ----------------------------------------------------------------------------
// ipv4 dotted text parser assertion macros
// immediate-implication and next-cycle forms of a clocked property
// ----------------------------------------------------------------------------
`ifndef IPV4_DOTTED_TEXT_PARSER_ASSERT_SVH
`define IPV4_DOTTED_TEXT_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define IDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("idp assertion failed");
// antecedent implies consequent in the next cycle
`define IDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("idp assertion failed");
`else
`define IDP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/idp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idp_pkg
// shared types and constants of the ipv4 dotted text parser
// ----------------------------------------------------------------------------
package idp_pkg;

	// characters looked at per text, rest ignored (15..31)
	localparam int MAX_CHARS = 28;
	localparam int CHARS_W   = 5;

	// queue between classifier and parse unit, depth a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = QUEUE_AW + 1;

	// input beat
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} char_beat_t;

	// output beat
	typedef struct packed {
		logic [31:0] address;
		logic        parse_error;
	} addr_beat_t;

	// character classes
	typedef enum logic [2:0] {
		CH_DEC,
		CH_HEXL,
		CH_X,
		CH_DOT,
		CH_TERM,
		CH_OTHER
	} char_kind_t;

	// classified character as it travels through the queue
	typedef struct packed {
		char_kind_t kind;
		logic [3:0] digit;
		logic       is_last;
	} char_class_t;

	// queue status toward front and back
	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	// parse phase within one part
	typedef enum logic [1:0] {
		PH_START,
		PH_ZERO,
		PH_DIGITS
	} scan_phase_t;

	// radix of the current part
	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} number_base_t;

endpackage
`default_nettype wire

[sv/ipv4_dotted_text_parser.sv]
// the last character is queued, then popped into the output register that holds its address beat
// throughput: one character per cycle unless stalled, set by the part update in the parse unit
// a four-entry queue lets the character side run on while the address beat is stalled
// reset: arst_n clears the queue, the parse state and the output valid at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser
// top level: character classifier, queue and parse unit
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 char_valid,
	output logic                char_stall,
	input  idp_pkg::char_beat_t char_data,
	output logic                addr_valid,
	input  wire                 addr_stall,
	output idp_pkg::addr_beat_t addr_data
);
	import idp_pkg::*;

	queue_status_t qstat;
	char_class_t   push_data;
	char_class_t   head;
	logic          push;
	logic          pop;

	// classify incoming beats
	idp_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	// decouple front from parse unit
	idp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// parse and pack
	idp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.addr_valid (addr_valid),
		.addr_stall (addr_stall),
		.addr_data  (addr_data)
	);

endmodule
`default_nettype wire

[sv/idp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idp_front
// accepts text beats and sorts each character into its class
// ----------------------------------------------------------------------------
module idp_front (
	input  wire                    char_valid,
	output logic                   char_stall,
	input  idp_pkg::char_beat_t    char_data,
	input  idp_pkg::queue_status_t qstat,
	output logic                   push,
	output idp_pkg::char_class_t   push_data
);
	import idp_pkg::*;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_CR    = 8'h0d;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DOT   = 8'h2e;
	localparam logic [7:0] CHR_D0    = 8'h30;
	localparam logic [7:0] CHR_D9    = 8'h39;
	localparam logic [7:0] CHR_UA    = 8'h41;
	localparam logic [7:0] CHR_UF    = 8'h46;
	localparam logic [7:0] CHR_UX    = 8'h58;
	localparam logic [7:0] CHR_LA    = 8'h61;
	localparam logic [7:0] CHR_LF    = 8'h66;
	localparam logic [7:0] CHR_LX    = 8'h78;

	logic [7:0] c;

	// handshake into the queue
	assign char_stall = qstat.full;
	assign push       = char_valid && !qstat.full;
	assign c          = char_data.char_code;

	// classify the character
	always_comb begin
		push_data.is_last = char_data.is_last;
		push_data.digit   = 4'd0;
		push_data.kind    = CH_OTHER;
		if (c >= CHR_D0 && c <= CHR_D9) begin
			push_data.kind  = CH_DEC;
			push_data.digit = c[3:0];
		end else if ((c >= CHR_LA && c <= CHR_LF) || (c >= CHR_UA && c <= CHR_UF)) begin
			push_data.kind  = CH_HEXL;
			push_data.digit = c[3:0] + 4'd9;
		end else if (c == CHR_LX || c == CHR_UX) begin
			push_data.kind = CH_X;
		end else if (c == CHR_DOT) begin
			push_data.kind = CH_DOT;
		end else if (c == CHR_NUL || c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR)) begin
			push_data.kind = CH_TERM;
		end
	end

endmodule
`default_nettype wire

[sv/idp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_dotted_text_parser_assert.svh"
// ----------------------------------------------------------------------------
// idp_queue
// short fifo of classified characters between front and parse unit
// ----------------------------------------------------------------------------
module idp_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  idp_pkg::char_class_t    push_data,
	input  wire                     pop,
	output idp_pkg::char_class_t    head,
	output idp_pkg::queue_status_t  qstat
);
	import idp_pkg::*;

	char_class_t         mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_CW-1:0] cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	assign head            = mem_q[rd_q];
	assign qstat.full      = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign qstat.not_empty = (cnt_q != '0);

	`IDP_ASSERT_NOW(a_no_push_full, clk, arst_n, push, cnt_q != QUEUE_CW'(QUEUE_DEPTH))
	`IDP_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, cnt_q != '0)
	`IDP_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule
`default_nettype wire

[sv/idp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_dotted_text_parser_assert.svh"
// ----------------------------------------------------------------------------
// idp_back
// parse unit: folds characters into parts, packs the address on the last beat
// ----------------------------------------------------------------------------
module idp_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  idp_pkg::queue_status_t qstat,
	input  idp_pkg::char_class_t   head,
	output logic                   pop,
	output logic                   addr_valid,
	input  wire                    addr_stall,
	output idp_pkg::addr_beat_t    addr_data
);
	import idp_pkg::*;

	// parse state
	scan_phase_t        phase_q, phase_d, step_phase;
	number_base_t       base_q, base_d, step_base;
	logic [31:0]        value_q, value_d, step_value;
	logic [7:0]         oct_q [3];
	logic [7:0]         oct_d [3];
	logic [7:0]         step_oct [3];
	logic [1:0]         count_q, count_d, step_count;
	logic [CHARS_W-1:0] chars_q, chars_d, step_chars;
	logic               ended_q, ended_d, step_ended;
	logic               failed_q, failed_d, step_failed;

	// output register
	logic       out_valid_q;
	addr_beat_t out_q;
	addr_beat_t result;

	logic         out_free;
	logic         do_digit;
	number_base_t base_eff;
	logic [31:0]  scaled;

	// a last beat needs the output register, others flow freely
	assign out_free = !out_valid_q || !addr_stall;
	assign pop      = qstat.not_empty && (!head.is_last || out_free);

	// effect of one character on the parse state
	always_comb begin
		step_phase  = phase_q;
		step_base   = base_q;
		step_value  = value_q;
		step_oct    = oct_q;
		step_count  = count_q;
		step_chars  = chars_q;
		step_ended  = ended_q;
		step_failed = failed_q;
		do_digit    = 1'b1;
		base_eff    = base_q;
		scaled      = '0;
		if (!ended_q && !failed_q) begin
			if (chars_q < CHARS_W'(MAX_CHARS)) begin
				step_chars = chars_q + 1'b1;
				// prefix handling
				unique case (phase_q)
					PH_START: begin
						if (head.kind == CH_DEC && head.digit == 4'd0) begin
							step_phase = PH_ZERO;
							do_digit   = 1'b0;
						end else begin
							base_eff   = BASE_DEC;
							step_phase = PH_DIGITS;
						end
					end
					PH_ZERO: begin
						step_phase = PH_DIGITS;
						if (head.kind == CH_X) begin
							step_base = BASE_HEX;
							do_digit  = 1'b0;
						end else begin
							base_eff = BASE_OCT;
						end
					end
					default: ;
				endcase
				// digit, separator or terminator
				if (do_digit) begin
					step_base = base_eff;
					unique case (base_eff)
						BASE_HEX: scaled = {value_q[27:0], 4'b0};
						BASE_OCT: scaled = {value_q[28:0], 3'b0};
						default:  scaled = {value_q[28:0], 3'b0} + {value_q[30:0], 1'b0};
					endcase
					unique case (head.kind)
						CH_DEC: begin
							step_value = scaled + {28'd0, head.digit};
						end
						CH_HEXL: begin
							if (base_eff == BASE_HEX)
								step_value = {value_q[27:0], head.digit};
							else
								step_failed = 1'b1;
						end
						CH_DOT: begin
							if (count_q == 2'd3 || |value_q[31:8]) begin
								step_failed = 1'b1;
							end else begin
								step_oct[count_q] = value_q[7:0];
								step_count        = count_q + 1'b1;
								step_value        = '0;
								step_base         = BASE_DEC;
								step_phase        = PH_START;
							end
						end
						CH_TERM: step_ended  = 1'b1;
						default: step_failed = 1'b1;
					endcase
				end
			end else begin
				step_ended = 1'b1;
			end
		end
	end

	// next state: apply the step on a pop, clear after the last beat
	always_comb begin
		phase_d  = phase_q;
		base_d   = base_q;
		value_d  = value_q;
		oct_d    = oct_q;
		count_d  = count_q;
		chars_d  = chars_q;
		ended_d  = ended_q;
		failed_d = failed_q;
		if (pop) begin
			if (head.is_last) begin
				phase_d  = PH_START;
				base_d   = BASE_DEC;
				value_d  = '0;
				oct_d    = '{default: 8'd0};
				count_d  = '0;
				chars_d  = '0;
				ended_d  = 1'b0;
				failed_d = 1'b0;
			end else begin
				phase_d  = step_phase;
				base_d   = step_base;
				value_d  = step_value;
				oct_d    = step_oct;
				count_d  = step_count;
				chars_d  = step_chars;
				ended_d  = step_ended;
				failed_d = step_failed;
			end
		end
	end

	// pack the parts and range check the final one
	always_comb begin
		logic bad;
		logic [31:0] v;
		bad = step_failed;
		v   = step_value;
		unique case (step_count)
			2'd0: ;
			2'd1: begin
				bad = bad || |step_value[31:24];
				v   = {step_oct[0], step_value[23:0]};
			end
			2'd2: begin
				bad = bad || |step_value[31:16];
				v   = {step_oct[0], step_oct[1], step_value[15:0]};
			end
			default: begin
				bad = bad || |step_value[31:8];
				v   = {step_oct[0], step_oct[1], step_oct[2], step_value[7:0]};
			end
		endcase
		result.address     = bad ? '1 : v;
		result.parse_error = bad;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			base_q   <= BASE_DEC;
			value_q  <= '0;
			oct_q    <= '{default: 8'd0};
			count_q  <= '0;
			chars_q  <= '0;
			ended_q  <= 1'b0;
			failed_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			base_q   <= base_d;
			value_q  <= value_d;
			oct_q    <= oct_d;
			count_q  <= count_d;
			chars_q  <= chars_d;
			ended_q  <= ended_d;
			failed_q <= failed_d;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && head.is_last)
			out_valid_q <= 1'b1;
		else if (!addr_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_last)
			out_q <= result;
	end

	assign addr_valid = out_valid_q;
	assign addr_data  = out_q;

	`IDP_ASSERT_NEXT(a_last_gives_beat, clk, arst_n, pop && head.is_last, out_valid_q)
	`IDP_ASSERT_NEXT(a_last_clears, clk, arst_n, pop && head.is_last, chars_q == '0 && !failed_q && count_q == '0)
	`IDP_ASSERT_NOW(a_err_all_ones, clk, arst_n, out_valid_q && out_q.parse_error, out_q.address == '1)
	`IDP_ASSERT_NOW(a_chars_bound, clk, arst_n, 1'b1, chars_q <= CHARS_W'(MAX_CHARS))

endmodule
`default_nettype wire

[bench/ipv4_dotted_text_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser_checker
// watches the character and address channels, keeps its own model of the
// parser state, and compares each address beat against the oldest prediction
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 char_valid,
	input  wire                 char_stall,
	input  idp_pkg::char_beat_t char_data,
	input  wire                 addr_valid,
	input  wire                 addr_stall,
	input  idp_pkg::addr_beat_t addr_data,
	output int                  fail_count,
	output int                  pending
);
	import idp_pkg::*;

	localparam logic [7:0] ASCII_NUL   = 8'h00;
	localparam logic [7:0] ASCII_TAB   = 8'h09;
	localparam logic [7:0] ASCII_CR    = 8'h0d;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_DOT   = 8'h2e;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_UP_A  = 8'h41;
	localparam logic [7:0] ASCII_UP_F  = 8'h46;
	localparam logic [7:0] ASCII_UP_X  = 8'h58;
	localparam logic [7:0] ASCII_LO_A  = 8'h61;
	localparam logic [7:0] ASCII_LO_F  = 8'h66;
	localparam logic [7:0] ASCII_LO_X  = 8'h78;

	// parse state of the text in flight
	scan_phase_t  phase      = PH_START;
	number_base_t radix_sel  = BASE_DEC;
	logic [31:0]  part_acc   = '0;
	logic [7:0]   held_octet [3];
	int           dots       = 0;
	int           char_total = 0;
	bit           text_done  = 1'b0;
	bit           text_bad   = 1'b0;

	// addresses predicted but not yet seen on the output
	addr_beat_t expected_addrs [$];

	function automatic bit is_space(input logic [7:0] c);
		return c == ASCII_SPACE || (c >= ASCII_TAB && c <= ASCII_CR);
	endfunction

	task automatic clear_text();
		phase      = PH_START;
		radix_sel  = BASE_DEC;
		part_acc   = '0;
		held_octet = '{8'h00, 8'h00, 8'h00};
		dots       = 0;
		char_total = 0;
		text_done  = 1'b0;
		text_bad   = 1'b0;
	endtask

	// a character once the base of the part is known
	task automatic take_digit(input logic [7:0] c);
		logic [31:0] mul;
		mul = (radix_sel == BASE_HEX) ? 32'd16 : (radix_sel == BASE_OCT) ? 32'd8 : 32'd10;
		if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
			// octal parts take 8 and 9 as plain values
			part_acc = part_acc * mul + 32'(c - ASCII_ZERO);
		end else if (radix_sel == BASE_HEX && c >= ASCII_LO_A && c <= ASCII_LO_F) begin
			part_acc = (part_acc << 4) + 32'(c - ASCII_LO_A) + 32'd10;
		end else if (radix_sel == BASE_HEX && c >= ASCII_UP_A && c <= ASCII_UP_F) begin
			part_acc = (part_acc << 4) + 32'(c - ASCII_UP_A) + 32'd10;
		end else if (c == ASCII_DOT) begin
			// a fourth dot or a dotted part over one byte rejects the text
			if (dots >= 3 || part_acc > 32'hff) begin
				text_bad = 1'b1;
			end else begin
				held_octet[dots] = part_acc[7:0];
				dots++;
				part_acc  = '0;
				radix_sel = BASE_DEC;
				phase     = PH_START;
			end
		end else if (c == ASCII_NUL || is_space(c)) begin
			text_done = 1'b1;
		end else begin
			text_bad = 1'b1;
		end
	endtask

	// prefix handling: leading 0 means octal, 0x or 0X means hex
	task automatic feed_char(input logic [7:0] c);
		if (phase == PH_START) begin
			if (c == ASCII_ZERO) begin
				phase = PH_ZERO;
				return;
			end
			radix_sel = BASE_DEC;
			phase     = PH_DIGITS;
		end else if (phase == PH_ZERO) begin
			phase = PH_DIGITS;
			if (c == ASCII_LO_X || c == ASCII_UP_X) begin
				radix_sel = BASE_HEX;
				return;
			end
			radix_sel = BASE_OCT;
		end
		take_digit(c);
	endtask

	// final packing with the range check of the last part
	function automatic addr_beat_t pack_address();
		logic [31:0] v;
		bit          bad;
		addr_beat_t  r;
		v   = part_acc;
		bad = text_bad;
		if (!bad) begin
			case (dots)
				0: ;
				1: if (v > 32'hffffff) bad = 1'b1;
					else v |= {held_octet[0], 24'h0};
				2: if (v > 32'hffff) bad = 1'b1;
					else v |= {held_octet[0], held_octet[1], 16'h0};
				default: if (v > 32'hff) bad = 1'b1;
					else v |= {held_octet[0], held_octet[1], held_octet[2], 8'h0};
			endcase
		end
		r.address     = bad ? 32'hffffffff : v;
		r.parse_error = bad;
		return r;
	endfunction

	task automatic take_char_beat(input char_beat_t b);
		if (!text_done && !text_bad) begin
			// characters past the limit end the text quietly
			if (char_total < MAX_CHARS) begin
				char_total++;
				feed_char(b.char_code);
			end else begin
				text_done = 1'b1;
			end
		end
		if (b.is_last) begin
			// end of text acts as a NUL
			if (!text_done && !text_bad)
				feed_char(ASCII_NUL);
			expected_addrs.push_back(pack_address());
			clear_text();
		end
	endtask

	// compare first, then predict, so a beat can never match its own text
	always @(posedge clk or negedge arst_n) begin
		addr_beat_t want;
		if (!arst_n) begin
			clear_text();
			expected_addrs.delete();
		end else begin
			if (addr_valid && !addr_stall) begin
				if (expected_addrs.size() == 0) begin
					$error("address beat with no text pending: address %h parse_error %b",
						addr_data.address, addr_data.parse_error);
					fail_count++;
				end else begin
					want = expected_addrs.pop_front();
					if (addr_data.address !== want.address) begin
						$error("address: expected %h, got %h", want.address, addr_data.address);
						fail_count++;
					end
					if (addr_data.parse_error !== want.parse_error) begin
						$error("parse_error: expected %b, got %b",
							want.parse_error, addr_data.parse_error);
						fail_count++;
					end
				end
			end
			if (char_valid && !char_stall)
				take_char_beat(char_data);
		end
		pending = expected_addrs.size();
	end

endmodule

[bench/ipv4_dotted_text_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser_tb
// feeds address text one character per beat: a directed set of corner texts,
// then random well-formed addresses with mixed bases, broken texts and noise,
// under random idling, a long output stall and a drain pause
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser_tb;
	import idp_pkg::*;

	localparam logic [7:0] TEXT_NUL = 8'h00;
	// bytes that end a parse without error
	localparam logic [7:0] TEXT_ENDERS [7] = '{8'h00, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20};
	localparam string      NOISE_SET   = "0123456789.xXabcdefABCDEFg-";
	localparam int         RANDOM_CHARS = 680;
	localparam int         HOLD_CYCLES  = 300;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	char_beat_t char_data  = '0;
	logic       addr_valid;
	logic       addr_stall = 1'b0;
	addr_beat_t addr_data;

	int fail_count;
	int pending;

	bit tx_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;
	int hold_ticket = 0;
	int sent_chars  = 0;

	logic [7:0] text_buf [$];

	ipv4_dotted_text_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data (char_data),
		.addr_valid(addr_valid),
		.addr_stall(addr_stall),
		.addr_data (addr_data)
	);

	ipv4_dotted_text_parser_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data (char_data),
		.addr_valid(addr_valid),
		.addr_stall(addr_stall),
		.addr_data (addr_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random stalls, plus a long counted hold on request
	initial begin
		int hold_left;
		int hold_served;
		hold_left   = 0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_ticket != hold_served) begin
				hold_served = hold_ticket;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				addr_stall <= 1'b1;
			end else begin
				addr_stall <= rx_idle_on && ($urandom_range(99) < 38);
			end
		end
	end

	// one character beat, held until accepted
	task automatic send_char(input logic [7:0] c, input bit last);
		while (tx_idle_on && $urandom_range(99) < 38) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= '{char_code: c, is_last: last};
		@(posedge clk);
		while (char_stall) @(posedge clk);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic send_text();
		if (text_buf.size() == 0)
			add_str("0");
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
		sent_chars += text_buf.size();
		text_buf.delete();
	endtask

	task automatic send_str(input string s);
		add_str(s);
		send_text();
	endtask

	// one part in a random base and letter case, sometimes empty
	task automatic add_part(input logic [31:0] v);
		string s;
		case ($urandom_range(9))
			0: s = "";
			1, 2: s = {"0", $sformatf("%0o", v)};
			3, 4: begin
				s = $sformatf("%0h", v);
				for (int i = 0; i < s.len(); i++)
					if ($urandom_range(1) && s[i] >= "a") s[i] = s[i] - 8'd32;
				if ($urandom_range(1)) s = {"0x", s};
				else s = {"0X", s};
			end
			// leading zero on decimal digits: octal that may hold 8 and 9
			5: s = {"0", $sformatf("%0d", v)};
			default: s = $sformatf("%0d", v);
		endcase
		add_str(s);
	endtask

	// one to four parts with mostly legal ranges, then an optional tail
	task automatic build_address();
		int          parts;
		logic [31:0] v;
		parts = $urandom_range(1, 4);
		for (int k = 0; k < parts; k++) begin
			if (k < parts - 1) begin
				v = ($urandom_range(9) == 0) ? $urandom_range(256, 400) : $urandom_range(0, 255);
			end else begin
				case ($urandom_range(3))
					0: v = $urandom;
					1: v = $urandom & (32'hffffffff >> (8 * (parts - 1)));
					default: v = $urandom_range(0, 255);
				endcase
			end
			add_part(v);
			if (k < parts - 1)
				add_str(".");
		end
		case ($urandom_range(11))
			0: begin
				add_str(".");
				add_part($urandom_range(0, 300));
			end
			1: begin
				text_buf.push_back(TEXT_ENDERS[$urandom_range(6)]);
				repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(255)));
			end
			2: text_buf.push_back(8'($urandom_range(255)));
			// leading zeros can push the text past the character limit
			3: repeat ($urandom_range(20, 30)) text_buf.push_front("0");
			default: ;
		endcase
	endtask

	task automatic build_noise();
		repeat ($urandom_range(1, 35)) begin
			if ($urandom_range(1))
				text_buf.push_back(8'($urandom_range(255)));
			else
				text_buf.push_back(NOISE_SET[$urandom_range(NOISE_SET.len() - 1)]);
		end
	endtask

	initial begin
		int text_no;
		@(posedge arst_n);
		@(posedge clk);

		// corner texts
		send_str("0");
		send_str("255.255.255.255");
		send_str("4294967295");
		send_str("4294967296");
		send_str("0x7f.1");
		send_str("0X1.0377.0xFFff");
		send_str("1.2.3.4.5");
		send_str("256.1");
		send_str("1.16777216");
		send_str("1.2.65536");
		send_str("1.2.3.256");
		send_str("09.019");
		send_str("0x");
		send_str("...");
		send_str("1.");
		send_str("1.2.3.4 x");
		send_str("1.2 ");
		send_str("1.2x");
		send_str("0000000000000000000000000001.7");
		add_str("1");
		text_buf.push_back(TEXT_NUL);
		add_str("zz");
		send_text();

		// random texts
		sent_chars = 0;
		text_no    = 0;
		while (sent_chars < RANDOM_CHARS) begin
			// quiet stretch with no idling on either side
			tx_idle_on = !(text_no >= 20 && text_no < 45);
			rx_idle_on = tx_idle_on;
			// long output hold while the sender keeps going
			if (text_no == 10) begin
				tx_idle_on = 1'b0;
				hold_ticket++;
				repeat (4) begin
					build_address();
					send_text();
				end
				tx_idle_on = 1'b1;
			end
			// sender pause until every address is out
			if (text_no == 32) begin
				char_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(4) == 0) build_noise();
			else build_address();
			send_text();
			text_no++;
		end
		char_valid <= 1'b0;

		// drain, then allow for the pipeline depth
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#500000;
		$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/idp_pkg.sv
sv/idp_front.sv
sv/idp_queue.sv
sv/idp_back.sv
sv/ipv4_dotted_text_parser.sv
bench/ipv4_dotted_text_parser_checker.sv
bench/ipv4_dotted_text_parser_tb.sv
